FILE: sv/hao_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hao_pkg
// shared constants, codes and control types of the harmonic additive oscillator
// ----------------------------------------------------------------------------
package hao_pkg;

    // parameter defaults
    localparam int DEF_SAMPLE_RATE      = 44100;
    localparam int DEF_HARMONIC_COUNT   = 8;
    localparam int DEF_SINE_TABLE_DEPTH = 1024;

    // fixed word widths
    localparam int PHASE_W      = 32;
    localparam int SAMPLE_W     = 13;
    localparam int AMP_W        = 15;
    localparam int WEIGHTS_W    = 64;
    localparam int FREQ_W       = 15;
    localparam int VIB_DEPTH_W  = 11;
    localparam int VIB_RATE_W   = 16;
    localparam int SINE_MAG_W   = 15;
    localparam int SINE_W       = 16;
    localparam int PROD_W       = 48;
    localparam int SUM_W        = 49;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // arithmetic constants
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int HARMONIC_FREQ_LIMIT      = 22000;
    localparam int SAMPLE_LIMIT             = 3000;
    localparam int SUM_FRAC_W               = 29;

    // divide-by-sample-rate unit
    localparam int DIV_W     = 48;
    localparam int DIV_DIGIT = 4;

    // register reset values
    localparam logic [AMP_W-1:0]       RST_AMPLITUDE    = 15'd500;
    localparam logic [WEIGHTS_W-1:0]   RST_WEIGHTS_LOW  = 64'd16384;
    localparam logic [WEIGHTS_W-1:0]   RST_WEIGHTS_HIGH = 64'd0;
    localparam logic [FREQ_W-1:0]      RST_TONE_FREQ    = 15'd440;
    localparam logic [VIB_DEPTH_W-1:0] RST_VIB_DEPTH    = 11'd0;
    localparam logic [VIB_RATE_W-1:0]  RST_VIB_RATE     = 16'd0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_DEPTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_RATE  = 3'd5;

    // shared multiplier operations
    typedef logic [1:0] t_mul_op;
    localparam t_mul_op MUL_NONE = 2'd0;
    localparam t_mul_op MUL_VIB  = 2'd1;
    localparam t_mul_op MUL_GAIN = 2'd2;
    localparam t_mul_op MUL_TERM = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic    start;
        logic    rom_rd;
        logic    rom_vib;
        t_mul_op mul_op;
        logic    acc_en;
        logic    harm_next;
        logic    div_start;
        logic    finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic harm_more;
        logic div_busy;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/hao_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hao_if
// valid/ready channels of the oscillator: sample tick in, audio word out
// ----------------------------------------------------------------------------
interface hao_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface hao_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [hao_pkg::SAMPLE_W-1:0] sample;
    logic                                clipped;

    modport source (output valid, output sample, output clipped, input ready);
    modport sink   (input valid, input sample, input clipped, output ready);
endinterface

FILE: sv/hao_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hao_div
// radix-16 restoring divider by the sample rate, two divisions per start
// ----------------------------------------------------------------------------
module hao_div #(
    parameter int SAMPLE_RATE = hao_pkg::DEF_SAMPLE_RATE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hao_pkg::DIV_W-1:0]    i_tone_dividend,
    input  logic [hao_pkg::DIV_W-1:0]    i_vib_dividend,
    output logic                         o_busy,
    output logic [hao_pkg::PHASE_W-1:0]  o_tone_quot,
    output logic [hao_pkg::PHASE_W-1:0]  o_vib_quot
);
    localparam int REM_W = $clog2(SAMPLE_RATE);
    localparam int STEPS = hao_pkg::DIV_W / hao_pkg::DIV_DIGIT;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DW    = hao_pkg::DIV_W;
    localparam int DG    = hao_pkg::DIV_DIGIT;
    localparam int QW    = hao_pkg::PHASE_W;

    logic             r_busy;
    logic             r_pass;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_num;
    logic [DW-1:0]    r_vib_num;
    logic [REM_W-1:0] r_rem;
    logic [QW-1:0]    r_quot;
    logic [QW-1:0]    r_tone_quot;

    logic [REM_W-1:0] w_rem;
    logic [QW-1:0]    w_quot;

    // four quotient bits per cycle
    always_comb begin
        logic [REM_W-1:0] rem_v;
        logic [REM_W:0]   t;
        logic [DG-1:0]    qd;
        rem_v = r_rem;
        qd    = '0;
        for (int i = 0; i < DG; i++) begin
            t = {rem_v, r_num[DW-1-i]};
            if (t >= (REM_W+1)'(SAMPLE_RATE)) begin
                t = t - (REM_W+1)'(SAMPLE_RATE);
                qd[DG-1-i] = 1'b1;
            end
            rem_v = t[REM_W-1:0];
        end
        w_rem  = rem_v;
        w_quot = {r_quot[QW-1-DG:0], qd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pass <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_pass    <= 1'b0;
            r_cnt     <= '0;
            r_num     <= i_tone_dividend;
            r_vib_num <= i_vib_dividend;
            r_rem     <= '0;
            r_quot    <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_cnt <= '0;
                if (!r_pass) begin
                    // tone quotient done, start on the vibrato step
                    r_tone_quot <= w_quot;
                    r_pass      <= 1'b1;
                    r_num       <= r_vib_num;
                    r_rem       <= '0;
                    r_quot      <= '0;
                end else begin
                    r_busy <= 1'b0;
                    r_quot <= w_quot;
                end
            end else begin
                r_cnt  <= r_cnt + 1'b1;
                r_num  <= r_num << DG;
                r_rem  <= w_rem;
                r_quot <= w_quot;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_tone_quot = r_tone_quot;
    assign o_vib_quot  = r_quot;

endmodule

FILE: sv/hao_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hao_datapath
// registers, phases, sine rom, shared multiplier, accumulator and output word
// ----------------------------------------------------------------------------
module hao_datapath #(
    parameter int SAMPLE_RATE      = hao_pkg::DEF_SAMPLE_RATE,
    parameter int HARMONIC_COUNT   = hao_pkg::DEF_HARMONIC_COUNT,
    parameter int SINE_TABLE_DEPTH = hao_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [hao_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hao_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_restart,
    input  hao_pkg::t_dp_cmd                      i_cmd,
    output hao_pkg::t_dp_status                   o_status,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [hao_pkg::SAMPLE_W-1:0]   o_out_sample,
    output logic                                  o_out_clipped
);
    localparam int PW     = hao_pkg::PHASE_W;
    localparam int IW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int K_W    = $clog2(HARMONIC_COUNT + 2);
    localparam int FACC_W = hao_pkg::FREQ_W + $clog2(HARMONIC_COUNT + 1);
    localparam int SW     = hao_pkg::SUM_W;
    localparam logic signed [SW-1:0] LIMIT =
        SW'(hao_pkg::SAMPLE_LIMIT) <<< hao_pkg::SUM_FRAC_W;
    localparam logic signed [SW-1:0] TRUNC_BIAS =
        (SW'(1) <<< hao_pkg::SUM_FRAC_W) - SW'(1);

    // quarter-wave entry, odd taylor terms up to x^11 in q30
    function automatic logic [hao_pkg::SINE_MAG_W-1:0] quarter_entry(input int unsigned j);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [64:0] acc;
        logic [63:0]        q;
        x   = (hao_pkg::HALF_PI_Q30 * 64'(j)) / SINE_TABLE_DEPTH;
        x2  = (x * x) >> 30;
        acc = $signed({1'b0, x});
        t   = ((x * x2) >> 30) / 6;
        acc = acc - $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 20;
        acc = acc + $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 42;
        acc = acc - $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 72;
        acc = acc + $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 110;
        acc = acc - $signed({1'b0, t});
        if (acc < 0) begin
            acc = '0;
        end
        q = (acc[63:0] + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[hao_pkg::SINE_MAG_W-1:0];
    endfunction

    // configuration registers
    logic [hao_pkg::AMP_W-1:0]       r_amplitude;
    logic [2*hao_pkg::WEIGHTS_W-1:0] r_weights;
    logic [hao_pkg::FREQ_W-1:0]      r_tone_freq;
    logic [hao_pkg::VIB_DEPTH_W-1:0] r_vib_depth;
    logic [hao_pkg::VIB_RATE_W-1:0]  r_vib_rate;

    // oscillator state and per-sample work registers
    logic [PW-1:0]                   r_tone_phase;
    logic [PW-1:0]                   r_vib_phase;
    logic [PW-1:0]                   r_harm_phase;
    logic [FACC_W-1:0]               r_freq_acc;
    logic [K_W-1:0]                  r_k;
    logic [hao_pkg::SINE_MAG_W-1:0]  r_rom;
    logic                            r_neg;
    logic signed [hao_pkg::PROD_W-1:0] r_prod;
    logic signed [SW-1:0]            r_sum;
    logic                            r_tone_neg;
    logic                            r_out_valid;
    logic signed [hao_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                            r_out_clipped;

    logic [hao_pkg::SINE_MAG_W-1:0]  w_rom [0:SINE_TABLE_DEPTH];
    logic [PW-1:0]                   w_rom_phase;
    logic [29+IW:0]                  w_scaled;
    logic [IW-1:0]                   w_idx;
    logic [IW-1:0]                   w_addr;
    logic signed [hao_pkg::SINE_W-1:0] w_sine;
    logic [2:0]                      w_widx;
    logic signed [15:0]              w_weight;
    logic signed [31:0]              w_mul_a;
    logic signed [hao_pkg::SINE_W-1:0] w_mul_b;
    logic signed [hao_pkg::PROD_W-1:0] w_mul;
    logic signed [32:0]              w_freq;
    logic [31:0]                     w_freq_mag;
    logic [hao_pkg::DIV_W-1:0]       w_tone_dividend;
    logic [hao_pkg::DIV_W-1:0]       w_vib_dividend;
    logic                            w_div_busy;
    logic [PW-1:0]                   w_tone_quot;
    logic [PW-1:0]                   w_vib_quot;
    logic [PW-1:0]                   w_tone_inc;
    logic signed [SW-1:0]            w_trunc;
    logic signed [hao_pkg::SAMPLE_W-1:0] w_sample;
    logic                            w_clipped;

    // sine rom contents, fixed at elaboration
    for (genvar j = 0; j <= SINE_TABLE_DEPTH; j++) begin : g_rom
        assign w_rom[j] = quarter_entry(j);
    end

    // rom address from phase: quadrant folding
    assign w_rom_phase = i_cmd.rom_vib ? r_vib_phase : r_harm_phase;
    assign w_scaled    = (30+IW)'(w_rom_phase[29:0]) * (30+IW)'(SINE_TABLE_DEPTH);
    assign w_idx       = w_scaled[29+IW:30];
    assign w_addr      = w_rom_phase[30] ? IW'(SINE_TABLE_DEPTH) - w_idx : w_idx;
    assign w_sine      = r_neg ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});

    always_ff @(posedge i_clk) begin
        if (i_cmd.rom_rd) begin
            r_rom <= w_rom[w_addr];
            r_neg <= w_rom_phase[31];
        end
    end

    // per-harmonic 16-bit weight, harmonic 1 in the lowest slice
    assign w_widx   = 3'(r_k - 1'b1);
    assign w_weight = $signed(r_weights[{w_widx, 4'b0} +: 16]);

    // shared multiplier
    always_comb begin
        case (i_cmd.mul_op)
            hao_pkg::MUL_VIB: begin
                w_mul_a = $signed({21'b0, r_vib_depth});
                w_mul_b = w_sine;
            end
            hao_pkg::MUL_GAIN: begin
                w_mul_a = $signed({17'b0, r_amplitude});
                w_mul_b = w_weight;
            end
            hao_pkg::MUL_TERM: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = w_sine;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // instantaneous frequency in q15, magnitude shifted up for the divider
    assign w_freq          = $signed({3'b0, r_tone_freq, 15'b0}) + $signed(r_prod[32:0]);
    assign w_freq_mag      = w_freq[32] ? 32'(-w_freq) : w_freq[31:0];
    assign w_tone_dividend = {w_freq_mag[30:0], 17'b0};
    assign w_vib_dividend  = {8'b0, r_vib_rate, 24'b0};

    hao_div #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_div (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_cmd.div_start),
        .i_tone_dividend (w_tone_dividend),
        .i_vib_dividend  (w_vib_dividend),
        .o_busy          (w_div_busy),
        .o_tone_quot     (w_tone_quot),
        .o_vib_quot      (w_vib_quot)
    );

    assign w_tone_inc = r_tone_neg ? -w_tone_quot : w_tone_quot;

    // saturation and truncation toward zero
    always_comb begin
        w_trunc = (r_sum < 0) ? ((r_sum + TRUNC_BIAS) >>> hao_pkg::SUM_FRAC_W)
                              : (r_sum >>> hao_pkg::SUM_FRAC_W);
        if (r_sum > LIMIT) begin
            w_sample  = hao_pkg::SAMPLE_W'(hao_pkg::SAMPLE_LIMIT);
            w_clipped = 1'b1;
        end else if (r_sum < -LIMIT) begin
            w_sample  = -hao_pkg::SAMPLE_W'(hao_pkg::SAMPLE_LIMIT);
            w_clipped = 1'b1;
        end else begin
            w_sample  = w_trunc[hao_pkg::SAMPLE_W-1:0];
            w_clipped = 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= hao_pkg::RST_AMPLITUDE;
            r_weights   <= {hao_pkg::RST_WEIGHTS_HIGH, hao_pkg::RST_WEIGHTS_LOW};
            r_tone_freq <= hao_pkg::RST_TONE_FREQ;
            r_vib_depth <= hao_pkg::RST_VIB_DEPTH;
            r_vib_rate  <= hao_pkg::RST_VIB_RATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hao_pkg::REG_AMPLITUDE:
                    r_amplitude <= i_cfg_data[hao_pkg::AMP_W-1:0];
                hao_pkg::REG_WEIGHTS_LOW:
                    r_weights[hao_pkg::WEIGHTS_W-1:0] <= i_cfg_data;
                hao_pkg::REG_WEIGHTS_HIGH:
                    r_weights[2*hao_pkg::WEIGHTS_W-1:hao_pkg::WEIGHTS_W] <= i_cfg_data;
                hao_pkg::REG_TONE_FREQ:
                    r_tone_freq <= i_cfg_data[hao_pkg::FREQ_W-1:0];
                hao_pkg::REG_VIBRATO_DEPTH:
                    r_vib_depth <= i_cfg_data[hao_pkg::VIB_DEPTH_W-1:0];
                hao_pkg::REG_VIBRATO_RATE:
                    r_vib_rate <= i_cfg_data[hao_pkg::VIB_RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_phase <= '0;
            r_vib_phase  <= '0;
        end else if (i_cmd.start && i_restart) begin
            r_tone_phase <= '0;
            r_vib_phase  <= '0;
        end else if (i_cmd.finish) begin
            r_tone_phase <= r_tone_phase + w_tone_inc;
            r_vib_phase  <= r_vib_phase + w_vib_quot;
        end
    end

    // harmonic walk, products and sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_harm_phase <= i_restart ? '0 : r_tone_phase;
            r_freq_acc   <= FACC_W'(r_tone_freq);
            r_k          <= K_W'(1);
        end else if (i_cmd.harm_next) begin
            r_harm_phase <= r_harm_phase + r_tone_phase;
            r_freq_acc   <= r_freq_acc + FACC_W'(r_tone_freq);
            r_k          <= r_k + 1'b1;
        end
        if (i_cmd.mul_op != hao_pkg::MUL_NONE) begin
            r_prod <= w_mul;
        end
        if (i_cmd.start) begin
            r_sum <= '0;
        end else if (i_cmd.acc_en) begin
            r_sum <= r_sum + SW'(r_prod);
        end
        if (i_cmd.div_start) begin
            r_tone_neg <= w_freq[32];
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid   <= 1'b1;
            r_out_sample  <= w_sample;
            r_out_clipped <= w_clipped;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.harm_more = (r_k <= K_W'(HARMONIC_COUNT))
                             && (r_freq_acc <= FACC_W'(hao_pkg::HARMONIC_FREQ_LIMIT));
    assign o_status.div_busy  = w_div_busy;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_out_clipped = r_out_clipped;

endmodule

FILE: sv/hao_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hao_ctrl
// sequencer for one sample: vibrato sine, divider launch, harmonic loop, output
// ----------------------------------------------------------------------------
module hao_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output hao_pkg::t_dp_cmd     o_cmd,
    input  hao_pkg::t_dp_status  i_status
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VADDR = 3'd1;
    localparam logic [2:0] S_VMUL  = 3'd2;
    localparam logic [2:0] S_DIVGO = 3'd3;
    localparam logic [2:0] S_HADDR = 3'd4;
    localparam logic [2:0] S_HMUL  = 3'd5;
    localparam logic [2:0] S_WAIT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_pend;
    logic       n_pend;

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_VADDR;
                end
            end
            S_VADDR: begin
                o_cmd.rom_rd  = 1'b1;
                o_cmd.rom_vib = 1'b1;
                n_state       = S_VMUL;
            end
            S_VMUL: begin
                o_cmd.mul_op = hao_pkg::MUL_VIB;
                n_state      = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_pend          = 1'b0;
                n_state         = S_HADDR;
            end
            S_HADDR: begin
                // add the previous harmonic's term while the next gain forms
                o_cmd.acc_en = r_pend;
                n_pend       = 1'b0;
                if (i_status.harm_more) begin
                    o_cmd.rom_rd = 1'b1;
                    o_cmd.mul_op = hao_pkg::MUL_GAIN;
                    n_state      = S_HMUL;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_HMUL: begin
                o_cmd.mul_op    = hao_pkg::MUL_TERM;
                o_cmd.harm_next = 1'b1;
                n_pend          = 1'b1;
                n_state         = S_HADDR;
            end
            S_WAIT: begin
                if (!i_status.div_busy && i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

FILE: sv/harmonic_additive_oscillator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_additive_oscillator_core
// additive synthesis oscillator, up to eight weighted harmonics with vibrato
// ----------------------------------------------------------------------------
// Each word on i_in is one sample tick and yields exactly one word on o_out:
// the sum of amplitude * weight[k] * sin(k * tone_phase) over the harmonics
// whose frequency k * tone_freq stays at or below 22000 hz, saturated to
// +-3000 with clipped raised when the sum goes beyond the rail. A tick with
// restart set clears both phases before its sample is formed. One tick is
// worked at a time. The output word turns valid in the same cycle that the
// sequencer is idle again and can take the next tick: the vibrato sine read,
// depth product and divider launch come first, then the divide-by-sample-rate
// unit runs two passes (tone increment, then vibrato increment) at four
// quotient bits a cycle, and a last step writes the output word and steps
// both phases. The divider sets the pace; the harmonic loop (an address and
// gain step and a term step per harmonic on the shared 32x16 multiplier and
// the registered sine rom, one more step to add the last term) runs under
// it. The output word sits in its own register, so the next tick is taken
// as soon as the sequencer is idle even if the last word has not yet been
// taken; a new word is only written once the previous one has left, and a
// stalled output holds the sequencer in its last step. Registers are to be
// written through i_cfg_we / i_cfg_index / i_cfg_data while no tick is in
// work; the block does not enforce this. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module harmonic_additive_oscillator_core #(
    parameter int SAMPLE_RATE      = hao_pkg::DEF_SAMPLE_RATE,
    parameter int HARMONIC_COUNT   = hao_pkg::DEF_HARMONIC_COUNT,
    parameter int SINE_TABLE_DEPTH = hao_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // register write port
    input  logic                           i_cfg_we,
    input  logic [hao_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hao_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample ticks in, audio words out
    hao_in_if.sink                         i_in,
    hao_out_if.source                      o_out
);
    hao_pkg::t_dp_cmd    w_cmd;
    hao_pkg::t_dp_status w_status;

    // sequencer: one tick in flight, drives the datapath step by step
    hao_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    // datapath: registers, phases, sine rom, multiplier, divider, output word
    hao_datapath #(
        .SAMPLE_RATE      (SAMPLE_RATE),
        .HARMONIC_COUNT   (HARMONIC_COUNT),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_restart     (i_in.restart),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_sample  (o_out.sample),
        .o_out_clipped (o_out.clipped)
    );

endmodule

FILE: sv/hao_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hao_checker
// port-level checks of the oscillator, bound to the top level
// ----------------------------------------------------------------------------
module hao_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [hao_pkg::SAMPLE_W-1:0] i_out_sample,
    input logic                                i_out_clipped
);
    localparam logic signed [hao_pkg::SAMPLE_W-1:0] RAIL =
        hao_pkg::SAMPLE_W'(hao_pkg::SAMPLE_LIMIT);

    // output word always within the rails
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_sample <= RAIL) && (i_out_sample >= -RAIL))
        else $error("sample beyond saturation rails");

    // clipped words sit exactly on a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_clipped |-> (i_out_sample == RAIL) || (i_out_sample == -RAIL))
        else $error("clipped word not on a rail");

    // one tick in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("tick accepted while another is in work");

    // no word can appear right after a tick is taken into an empty output
    a_no_early_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("output word too early after tick");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sample) && $stable(i_out_clipped))
        else $error("stalled output word changed");

endmodule

bind harmonic_additive_oscillator_core hao_checker u_hao_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_sample  (o_out.sample),
    .i_out_clipped (o_out.clipped)
);
